// ----- sv/cna_pkg.sv -----
// Package for the complex number ALU: transaction structs, mode codes,
// pipeline widths and the 16-bit saturation helper. No dependencies.
`timescale 1ns / 1ps

package cna_pkg;

    // Fraction bits of the Q format (Q4.12 by default, valid 4..14).
    localparam int FRAC_BITS = 12;

    localparam int DATA_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;        // one 16x16 product
    localparam int SUM_W   = PROD_W + 1;        // sum of two products
    localparam int WIDE_W  = SUM_W + 1;         // saturation input width
    localparam int REM_W   = PROD_W;            // divisor and remainder width
    localparam int QUO_W   = DATA_W + 1;        // quotient bits kept
    localparam int DVD_W   = PROD_W + FRAC_BITS; // |numerator| << FRAC_BITS
    localparam int HI_W    = DVD_W - QUO_W;
    localparam int FRONT_STAGES = 3;
    // Edges from an accepted start to the matching done strobe.
    localparam int PIPE_LAT = FRONT_STAGES + QUO_W + 1;

    typedef enum logic [3:0] {
        MODE_ADD    = 4'd0,
        MODE_SUB    = 4'd1,
        MODE_MUL    = 4'd2,
        MODE_DIV    = 4'd3,
        MODE_CONJ   = 4'd4,
        MODE_EQ     = 4'd5,
        MODE_NE     = 4'd6,
        MODE_LT     = 4'd7,
        MODE_GT     = 4'd8,
        MODE_LE     = 4'd9,
        MODE_GE     = 4'd10,
        MODE_ISZERO = 4'd11,
        MODE_INC    = 4'd12,
        MODE_DEC    = 4'd13
    } mode_t;

    typedef struct packed {
        logic [3:0]               mode;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        logic                     flag;
        logic                     error_code;
        logic                     saturated;
    } out_t;

    // One divider lane: partial remainder, remaining dividend bits, quotient.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] dvd;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    // Side data that rides along the divider pipeline.
    typedef struct packed {
        logic             is_div;
        logic             dz;
        logic [REM_W-1:0] den;
        out_t             res;
    } side_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     sat;
    } sat_t;

    function automatic sat_t sat16(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        r.sat = 1'b0;
        r.val = v[DATA_W-1:0];
        if (v > WIDE_W'(32767)) begin
            r.val = 16'sh7FFF;
            r.sat = 1'b1;
        end else if (v < -WIDE_W'(32768)) begin
            r.val = 16'sh8000;
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- sv/cna_front.sv -----
// Front end of the complex number ALU: products, sums, simple modes and
// divider setup over three register stages. Depends on cna_pkg.
`timescale 1ns / 1ps

module cna_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  cna_pkg::in_t            operands,
    output logic                    out_valid,
    output cna_pkg::side_t          side,
    output cna_pkg::div_lane_t      lane_re,
    output cna_pkg::div_lane_t      lane_im
);

    localparam logic signed [cna_pkg::WIDE_W-1:0] ONE =
        cna_pkg::WIDE_W'(1) <<< cna_pkg::FRAC_BITS;
    localparam logic signed [cna_pkg::WIDE_W-1:0] RND_BIAS = ONE - 1;

    // stage 1
    logic v1_reg, v2_reg, v3_reg;
    logic [3:0] mode1_reg, mode2_reg;
    logic signed [cna_pkg::PROD_W-1:0] arbr_reg, aibi_reg, arbi_reg, aibr_reg;
    logic signed [cna_pkg::PROD_W-1:0] arar_reg, aiai_reg, brbr_reg, bibi_reg;
    cna_pkg::out_t simple_next, simple1_reg, simple2_reg;

    // stage 2
    logic signed [cna_pkg::SUM_W-1:0] mul_re_reg, mul_im_reg, num_re_reg, num_im_reg;
    logic [cna_pkg::REM_W-1:0] den_reg, mag_a_reg, mag_b_reg;

    // stage 3
    cna_pkg::side_t     side_next, side_reg;
    cna_pkg::div_lane_t lre_next, lim_next, lre_reg, lim_reg;

    function automatic logic signed [cna_pkg::WIDE_W-1:0] wx(
        input logic signed [cna_pkg::DATA_W-1:0] v);
        return cna_pkg::WIDE_W'(v);
    endfunction

    function automatic cna_pkg::div_lane_t div_setup(
        input logic signed [cna_pkg::SUM_W-1:0] num,
        input logic [cna_pkg::REM_W-1:0] den);
        cna_pkg::div_lane_t l;
        logic [cna_pkg::SUM_W-1:0] absn;
        logic [cna_pkg::DVD_W-1:0] dvd;
        logic [cna_pkg::HI_W-1:0]  hi;
        absn = num[cna_pkg::SUM_W-1] ? cna_pkg::SUM_W'(-num) : cna_pkg::SUM_W'(num);
        dvd  = {absn[cna_pkg::PROD_W-1:0], {cna_pkg::FRAC_BITS{1'b0}}};
        hi   = dvd[cna_pkg::DVD_W-1:cna_pkg::QUO_W];
        l.rem = cna_pkg::REM_W'(hi);
        l.dvd = dvd[cna_pkg::QUO_W-1:0];
        l.quo = '0;
        l.neg = num[cna_pkg::SUM_W-1];
        l.ovf = (cna_pkg::REM_W'(hi) >= den);
        return l;
    endfunction

    // Modes that need no product finish here.
    always_comb
    begin
        cna_pkg::sat_t s_re, s_im;
        s_re = '0;
        s_im = '0;
        simple_next = '0;
        case (cna_pkg::mode_t'(operands.mode))
            cna_pkg::MODE_ADD: begin
                s_re = cna_pkg::sat16(wx(operands.a_re) + wx(operands.b_re));
                s_im = cna_pkg::sat16(wx(operands.a_im) + wx(operands.b_im));
            end
            cna_pkg::MODE_SUB: begin
                s_re = cna_pkg::sat16(wx(operands.a_re) - wx(operands.b_re));
                s_im = cna_pkg::sat16(wx(operands.a_im) - wx(operands.b_im));
            end
            cna_pkg::MODE_CONJ: begin
                s_re = cna_pkg::sat16(wx(operands.a_re));
                s_im = cna_pkg::sat16(-wx(operands.a_im));
            end
            cna_pkg::MODE_INC: begin
                s_re = cna_pkg::sat16(wx(operands.a_re) + ONE);
                s_im = cna_pkg::sat16(wx(operands.a_im) + ONE);
            end
            cna_pkg::MODE_DEC: begin
                s_re = cna_pkg::sat16(wx(operands.a_re) - ONE);
                s_im = cna_pkg::sat16(wx(operands.a_im) - ONE);
            end
            cna_pkg::MODE_EQ:
                simple_next.flag = (operands.a_re == operands.b_re) &&
                                   (operands.a_im == operands.b_im);
            cna_pkg::MODE_NE:
                simple_next.flag = !((operands.a_re == operands.b_re) &&
                                     (operands.a_im == operands.b_im));
            cna_pkg::MODE_ISZERO:
                simple_next.flag = (operands.a_re == '0) && (operands.a_im == '0);
            default: ;
        endcase
        simple_next.res_re    = s_re.val;
        simple_next.res_im    = s_im.val;
        simple_next.saturated = s_re.sat | s_im.sat;
    end

    always_ff @(posedge clk)
    begin
        mode1_reg   <= operands.mode;
        simple1_reg <= simple_next;
        arbr_reg <= operands.a_re * operands.b_re;
        aibi_reg <= operands.a_im * operands.b_im;
        arbi_reg <= operands.a_re * operands.b_im;
        aibr_reg <= operands.a_im * operands.b_re;
        arar_reg <= operands.a_re * operands.a_re;
        aiai_reg <= operands.a_im * operands.a_im;
        brbr_reg <= operands.b_re * operands.b_re;
        bibi_reg <= operands.b_im * operands.b_im;

        mode2_reg   <= mode1_reg;
        simple2_reg <= simple1_reg;
        mul_re_reg  <= cna_pkg::SUM_W'(arbr_reg) - cna_pkg::SUM_W'(aibi_reg);
        mul_im_reg  <= cna_pkg::SUM_W'(arbi_reg) + cna_pkg::SUM_W'(aibr_reg);
        num_re_reg  <= cna_pkg::SUM_W'(arbr_reg) + cna_pkg::SUM_W'(aibi_reg);
        num_im_reg  <= cna_pkg::SUM_W'(aibr_reg) - cna_pkg::SUM_W'(arbi_reg);
        // squares are non-negative and below 2^31 each
        den_reg   <= cna_pkg::REM_W'(brbr_reg) + cna_pkg::REM_W'(bibi_reg);
        mag_a_reg <= cna_pkg::REM_W'(arar_reg) + cna_pkg::REM_W'(aiai_reg);
        mag_b_reg <= cna_pkg::REM_W'(brbr_reg) + cna_pkg::REM_W'(bibi_reg);

        side_reg <= side_next;
        lre_reg  <= lre_next;
        lim_reg  <= lim_next;
    end

    always_comb
    begin
        logic signed [cna_pkg::WIDE_W-1:0] wre, wim;
        cna_pkg::sat_t s_re, s_im;
        logic lt, gt;
        wre = cna_pkg::WIDE_W'(mul_re_reg);
        wim = cna_pkg::WIDE_W'(mul_im_reg);
        // truncate toward zero: bias negatives before the arithmetic shift
        wre = $signed(wre + (wre[cna_pkg::WIDE_W-1] ? RND_BIAS : '0)) >>>
              cna_pkg::FRAC_BITS;
        wim = $signed(wim + (wim[cna_pkg::WIDE_W-1] ? RND_BIAS : '0)) >>>
              cna_pkg::FRAC_BITS;
        s_re = cna_pkg::sat16(wre);
        s_im = cna_pkg::sat16(wim);
        lt = mag_a_reg < mag_b_reg;
        gt = mag_b_reg < mag_a_reg;

        side_next.is_div = (cna_pkg::mode_t'(mode2_reg) == cna_pkg::MODE_DIV);
        side_next.dz     = (den_reg == '0);
        side_next.den    = den_reg;
        side_next.res    = simple2_reg;
        case (cna_pkg::mode_t'(mode2_reg))
            cna_pkg::MODE_MUL: begin
                side_next.res.res_re    = s_re.val;
                side_next.res.res_im    = s_im.val;
                side_next.res.saturated = s_re.sat | s_im.sat;
            end
            cna_pkg::MODE_LT: side_next.res.flag = lt;
            cna_pkg::MODE_GT: side_next.res.flag = gt;
            cna_pkg::MODE_LE: side_next.res.flag = !gt;
            cna_pkg::MODE_GE: side_next.res.flag = !lt;
            default: ;
        endcase
        lre_next = div_setup(num_re_reg, den_reg);
        lim_next = div_setup(num_im_reg, den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign side      = side_reg;
    assign lane_re   = lre_reg;
    assign lane_im   = lim_reg;

endmodule

// ----- sv/cna_div_step.sv -----
// One registered restoring-division step (one quotient bit per stage).
// Depends on cna_pkg.
`timescale 1ns / 1ps

module cna_div_step (
    input  logic                        clk,
    input  logic [cna_pkg::REM_W-1:0]   den,
    input  cna_pkg::div_lane_t          lane_in,
    output cna_pkg::div_lane_t          lane_out
);

    cna_pkg::div_lane_t lane_next, lane_reg;

    always_comb
    begin
        logic [cna_pkg::REM_W:0] trial;
        logic [cna_pkg::REM_W:0] diff;
        logic                    qbit;
        trial = {lane_in.rem, lane_in.dvd[cna_pkg::QUO_W-1]};
        diff  = trial - {1'b0, den};
        qbit  = (trial >= {1'b0, den});
        lane_next     = lane_in;
        lane_next.rem = qbit ? diff[cna_pkg::REM_W-1:0] : trial[cna_pkg::REM_W-1:0];
        lane_next.dvd = {lane_in.dvd[cna_pkg::QUO_W-2:0], 1'b0};
        lane_next.quo = {lane_in.quo[cna_pkg::QUO_W-2:0], qbit};
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

// ----- sv/complex_number_alu.sv -----
// Top level of the complex number ALU: front end, two divider lanes and the
// result register. Depends on cna_pkg, cna_front and cna_div_step.
`timescale 1ns / 1ps

// Fully pipelined complex ALU on Q4.12 operands. A transaction is taken on
// every edge where start is high; busy is always low, so a new transaction can
// be issued every cycle. Each transaction returns exactly one result, shown on
// the result port for one cycle with done high. Behind three stages of
// multipliers, sums and setup, the divider runs 17 restoring steps, one
// quotient bit per register stage, before the result register. All modes
// take the same path length so results leave in issue order. The receiver
// cannot stall the block and must capture result whenever done is high.
module complex_number_alu (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  cna_pkg::in_t    operands,
    output logic            done,
    output cna_pkg::out_t   result
);

    localparam int QW = cna_pkg::QUO_W;

    logic                 fv;
    cna_pkg::side_t       fside;
    cna_pkg::div_lane_t   fre, fim;

    // Side data and valid bits travel alongside the divider stages.
    logic                 valid_reg [QW];
    cna_pkg::side_t       side_reg  [QW];
    cna_pkg::div_lane_t   lre [QW+1];
    cna_pkg::div_lane_t   lim [QW+1];

    cna_pkg::out_t        res_next, res_reg;
    logic                 done_reg;

    assign busy = 1'b0;

    cna_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .operands  (operands),
        .out_valid (fv),
        .side      (fside),
        .lane_re   (fre),
        .lane_im   (fim)
    );

    assign lre[0] = fre;
    assign lim[0] = fim;

    genvar g;
    generate
        for (g = 0; g < QW; g++)
        begin : g_div
            cna_div_step u_re (
                .clk      (clk),
                .den      ((g == 0) ? fside.den : side_reg[(g == 0) ? 0 : g-1].den),
                .lane_in  (lre[g]),
                .lane_out (lre[g+1])
            );
            cna_div_step u_im (
                .clk      (clk),
                .den      ((g == 0) ? fside.den : side_reg[(g == 0) ? 0 : g-1].den),
                .lane_in  (lim[g]),
                .lane_out (lim[g+1])
            );

            always_ff @(posedge clk)
            begin
                side_reg[g] <= (g == 0) ? fside : side_reg[(g == 0) ? 0 : g-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else
                begin
                    valid_reg[g] <= (g == 0) ? fv : valid_reg[(g == 0) ? 0 : g-1];
                end
            end
        end
    endgenerate

    function automatic cna_pkg::sat_t div_finish(input cna_pkg::div_lane_t l);
        cna_pkg::sat_t r;
        logic signed [cna_pkg::WIDE_W-1:0] q;
        q = cna_pkg::WIDE_W'({1'b0, l.quo});
        if (l.neg)
        begin
            q = -q;
        end
        r = cna_pkg::sat16(q);
        // quotient too large for the kept bits: clamp by sign
        if (l.ovf)
        begin
            r.val = l.neg ? 16'sh8000 : 16'sh7FFF;
            r.sat = 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        cna_pkg::sat_t q_re, q_im;
        q_re = div_finish(lre[QW]);
        q_im = div_finish(lim[QW]);
        res_next = side_reg[QW-1].res;
        if (side_reg[QW-1].is_div)
        begin
            res_next = '0;
            if (side_reg[QW-1].dz)
            begin
                res_next.error_code = 1'b1;
            end
            else
            begin
                res_next.res_re    = q_re.val;
                res_next.res_im    = q_im.val;
                res_next.saturated = q_re.sat | q_im.sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[QW-1];
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTH
    // Every transaction comes out after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(cna_pkg::PIPE_LAT) done)
        else $error("result missing after pipeline latency");

    // Divide by zero returns a clean zero result.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.error_code) |->
            (result.res_re == '0 && result.res_im == '0 && !result.saturated))
        else $error("division by zero result not cleared");

    // Boolean answers never come with saturation or an error.
    a_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.flag) |->
            (!result.saturated && !result.error_code && result.res_re == '0))
        else $error("flag result carries arithmetic status");
`endif

endmodule
